// ===== src/spt_pkg.sv =====
// ---------------------------------------------------------------------------
// spt_pkg: shared types and constants of the spin tachometer
// Register map, reset values, divider widths and the control FSM type.
// ---------------------------------------------------------------------------
package spt_pkg;

	// register map (index = paddr[3:2])
	localparam logic [1:0] REG_MAGNETS    = 2'd0;
	localparam logic [1:0] REG_TIMEOUT    = 2'd1;
	localparam logic [1:0] REG_MIN_PULSES = 2'd2;

	localparam logic [4:0]  MAGNETS_RST    = 5'd3;
	localparam logic [15:0] TIMEOUT_RST    = 16'd2000;
	localparam logic [7:0]  MIN_PULSES_RST = 8'd5;

	localparam int unsigned MAX_SPINS_DEF = 64;
	localparam int unsigned TALLY_W       = 7;

	// serial divider: 37-bit dividend (magnets * span), 16-bit divisor
	localparam int unsigned DVD_W  = 37;
	localparam int unsigned DVS_W  = 16;
	localparam int unsigned STEP_W = 6;

	localparam logic [STEP_W-1:0] PERIOD_STEPS = STEP_W'(DVD_W);
	localparam logic [STEP_W-1:0] RPM_STEPS    = STEP_W'(DVS_W);

	localparam logic [DVS_W-1:0] RPM_NUMER = 16'd60000;
	localparam logic [15:0]      RPM_SAT   = 16'hFFFF;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_P,
		ST_DIV_R,
		ST_DONE
	} state_t;

endpackage

// ===== src/spt_serdiv.sv =====
// ---------------------------------------------------------------------------
// spt_serdiv: bit-serial restoring divider
// One quotient bit per cycle, dividend MSB first; run length set per request.
// ---------------------------------------------------------------------------
module spt_serdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  spt_pkg::div_req_t req,
	output spt_pkg::div_rsp_t rsp
);
	import spt_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = (rem_sh >= {1'b0, dvs_q});
		rem_nx = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/spin_tachometer.sv =====
// ---------------------------------------------------------------------------
// spin_tachometer: pulse-period tachometer for a magnetic spinner
// Turns periodic pulse reports into rpm, peak rpm and spin bookkeeping.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one report request: pulse
//    count, time of the latest pulse and current time, both times in ms.
//  - Output channel (out_valid/out_stall) returns one result request per
//    report. The result sits in an output register, so a new report is
//    taken while the previous result still waits for the receiver.
//  - A report that measures rpm (nonzero count while spinning) goes from
//    acceptance to out_valid through ST_MUL, a 37-step serial division
//    for the period, a 16-step serial division for rpm, ST_DONE and the
//    output register; a period of 0 or over 60000 skips the rpm division.
//    Both divisions share the single one-bit-per-cycle divider, and the
//    next report is accepted only once the FSM is back in ST_IDLE.
//  - All other reports (spin start, timeout, nothing to do) go from
//    acceptance through ST_DONE to the output register and out_valid.
//  - Config registers on the APB port (pready tied high); write only while idle.
//  - Reset clears all spin state and loads the register defaults.
//  - With out_stall held, the finished result holds; one more report may
//    be accepted and computed, then in_stall stays high until space frees.
// ---------------------------------------------------------------------------
module spin_tachometer #(
	parameter int unsigned MAX_SPINS = spt_pkg::MAX_SPINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// report requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pulse_count,
	input  logic [31:0] pulse_time,
	input  logic [31:0] now_time,
	// result requests
	output logic        out_valid,
	input  logic        out_stall,
	output logic        refresh,
	output logic        is_spinning,
	output logic [15:0] rpm,
	output logic [15:0] max_rpm,
	output logic [31:0] spin_pulses,
	output logic [31:0] spin_duration,
	output logic [6:0]  spins_recorded
);
	import spt_pkg::*;

	localparam logic [TALLY_W-1:0] MaxSpinsW = TALLY_W'(MAX_SPINS);

	// ---------------- configuration registers ----------------
	logic [4:0]  magnets_q;
	logic [15:0] timeout_q;
	logic [7:0]  min_pulses_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnets_q    <= MAGNETS_RST;
			timeout_q    <= TIMEOUT_RST;
			min_pulses_q <= MIN_PULSES_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAGNETS:    magnets_q    <= pwdata[4:0];
				REG_TIMEOUT:    timeout_q    <= pwdata[15:0];
				REG_MIN_PULSES: min_pulses_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MAGNETS:    prdata = {27'd0, magnets_q};
			REG_TIMEOUT:    prdata = {16'd0, timeout_q};
			REG_MIN_PULSES: prdata = {24'd0, min_pulses_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- control FSM ----------------
	state_t state_q, state_d;

	logic in_acc;
	logic out_free;
	logic upd_en;

	// captured report
	logic [15:0] cnt_q;
	logic [31:0] ptime_q;
	logic [31:0] ntime_q;

	// spin state
	logic        spinning_q;
	logic [31:0] last_q;
	logic [31:0] start_q;
	logic [31:0] total_q;
	logic [15:0] cur_rpm_q;
	logic [15:0] peak_q;
	logic [31:0] dur_q;
	logic [6:0]  tally_q;

	// rpm result of the division chain
	logic [15:0] rpm_calc_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [31:0]      span;
	logic [DVD_W-1:0] product;
	logic             per_zero;
	logic             per_big;

	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid | ~out_stall;

	assign span     = ptime_q - last_q;
	assign product  = DVD_W'(magnets_q) * DVD_W'(span);
	assign per_zero = (div_rsp.quotient == '0);
	assign per_big  = (div_rsp.quotient > DVD_W'(RPM_NUMER));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ((pulse_count != '0) && spinning_q) ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: state_d = ST_DIV_P;
			ST_DIV_P: begin
				if (div_rsp.done) begin
					state_d = (per_zero || per_big) ? ST_DONE : ST_DIV_R;
				end
			end
			ST_DIV_R: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_stall         = 1'b1;
		upd_en           = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = PERIOD_STEPS;
		div_req.dividend = product;
		div_req.divisor  = cnt_q;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_MUL:  div_req.start = 1'b1;
			ST_DIV_P: begin
				// rpm = 60000 / period; numerator aligned to the dividend top
				div_req.start    = div_rsp.done & ~per_zero & ~per_big;
				div_req.steps    = RPM_STEPS;
				div_req.dividend = {RPM_NUMER, (DVD_W-DVS_W)'(0)};
				div_req.divisor  = div_rsp.quotient[DVS_W-1:0];
			end
			ST_DIV_R: ;
			ST_DONE:  upd_en = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	spt_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// capture report and rpm result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt_q   <= pulse_count;
			ptime_q <= pulse_time;
			ntime_q <= now_time;
		end
		if (state_q == ST_DIV_P && div_rsp.done) begin
			if (per_zero) begin
				rpm_calc_q <= RPM_SAT;
			end else if (per_big) begin
				rpm_calc_q <= '0;
			end
		end else if (state_q == ST_DIV_R && div_rsp.done) begin
			rpm_calc_q <= div_rsp.quotient[15:0];
		end
	end

	// ---------------- spin bookkeeping ----------------
	logic        spinning_d;
	logic [31:0] last_d;
	logic [31:0] start_d;
	logic [31:0] total_d;
	logic [15:0] cur_rpm_d;
	logic [15:0] peak_d;
	logic [31:0] dur_d;
	logic [6:0]  tally_d;
	logic        refresh_d;
	logic [32:0] sum;
	logic [31:0] gap;
	logic        timed_out;

	always_comb begin
		spinning_d = spinning_q;
		last_d     = last_q;
		start_d    = start_q;
		total_d    = total_q;
		cur_rpm_d  = cur_rpm_q;
		peak_d     = peak_q;
		dur_d      = dur_q;
		tally_d    = tally_q;
		refresh_d  = 1'b0;
		sum        = {1'b0, total_q} + {17'd0, cnt_q};
		gap        = ntime_q - ptime_q;
		timed_out  = (gap > {16'd0, timeout_q});
		if (cnt_q != '0) begin
			if (spinning_q) begin
				// rpm measurement
				cur_rpm_d = rpm_calc_q;
				if (rpm_calc_q > peak_q) begin
					peak_d = rpm_calc_q;
				end
				last_d    = ptime_q;
				total_d   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				dur_d     = ntime_q - start_q;
				refresh_d = 1'b1;
			end else begin
				// spin start
				spinning_d = 1'b1;
				total_d    = {16'd0, cnt_q};
				start_d    = ptime_q;
				last_d     = ptime_q;
				cur_rpm_d  = '0;
				dur_d      = '0;
			end
		end else if (spinning_q && timed_out) begin
			// spin end
			spinning_d = 1'b0;
			dur_d      = ntime_q - start_q;
			cur_rpm_d  = '0;
			if (total_q > {24'd0, min_pulses_q} && tally_q < MaxSpinsW) begin
				tally_d = tally_q + 7'd1;
			end
			refresh_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spinning_q <= 1'b0;
			last_q     <= '0;
			start_q    <= '0;
			total_q    <= '0;
			cur_rpm_q  <= '0;
			peak_q     <= '0;
			dur_q      <= '0;
			tally_q    <= '0;
		end else if (upd_en) begin
			spinning_q <= spinning_d;
			last_q     <= last_d;
			start_q    <= start_d;
			total_q    <= total_d;
			cur_rpm_q  <= cur_rpm_d;
			peak_q     <= peak_d;
			dur_q      <= dur_d;
			tally_q    <= tally_d;
		end
	end

	// ---------------- output register ----------------
	logic        out_valid_q;
	logic        refresh_q;
	logic        is_spinning_q;
	logic [15:0] rpm_q;
	logic [15:0] max_rpm_q;
	logic [31:0] spin_pulses_q;
	logic [31:0] spin_duration_q;
	logic [6:0]  spins_recorded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			refresh_q        <= refresh_d;
			is_spinning_q    <= spinning_d;
			rpm_q            <= spinning_d ? cur_rpm_d : 16'd0;
			max_rpm_q        <= peak_d;
			spin_pulses_q    <= total_d;
			spin_duration_q  <= dur_d;
			spins_recorded_q <= tally_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign refresh        = refresh_q;
	assign is_spinning    = is_spinning_q;
	assign rpm            = rpm_q;
	assign max_rpm        = max_rpm_q;
	assign spin_pulses    = spin_pulses_q;
	assign spin_duration  = spin_duration_q;
	assign spins_recorded = spins_recorded_q;

endmodule

// ===== src/spt_checker.sv =====
// ---------------------------------------------------------------------------
// spt_checker: port-level checks for the spin tachometer
// Watches the request channels and result fields; bound to the top level.
// ---------------------------------------------------------------------------
module spt_checker #(
	parameter int unsigned MAX_SPINS = spt_pkg::MAX_SPINS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        is_spinning,
	input logic [15:0] rpm,
	input logic [15:0] max_rpm,
	input logic [6:0]  spins_recorded
);
	import spt_pkg::*;

	localparam logic [TALLY_W-1:0] MaxSpinsW = TALLY_W'(MAX_SPINS);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one report in flight: accept is followed by stall
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second report accepted back to back");

	a_rpm_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_spinning |-> rpm == 16'd0)
		else $error("nonzero rpm while not spinning");

	a_rpm_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rpm <= max_rpm)
		else $error("rpm above peak");

	a_tally_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> spins_recorded <= MaxSpinsW)
		else $error("spin tally above capacity");

endmodule

bind spin_tachometer spt_checker #(.MAX_SPINS(MAX_SPINS)) u_spt_checker (.*);
